FILE: rtl/core/vdh_pkg.sv
// Shared types and constants for the vertex deduplication table.
package vdh_pkg;

	localparam int COORD_W = 32;
	localparam int IDX_W   = 20;

	// Stream payload layout
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 2;

	// tuser bit positions on the result stream
	localparam int USER_FOUND    = 0;
	localparam int USER_OVERFLOW = 1;

	// One way of a bucket row
	typedef struct packed {
		logic               vld;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [IDX_W-1:0]   orig;
		logic [IDX_W-1:0]   comp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CMP
	} state_t;

endpackage

FILE: rtl/core/vdh_ram.sv
// Single-port-write, single-port-read bucket row memory with registered read data.
module vdh_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 548
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/vdh_hash.sv
// Bucket hash: non-negative remainder of the coordinate sum by the bucket count.
module vdh_hash #(
	parameter int BUCKETS = 256,
	parameter int BW      = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vdh_pkg::COORD_W-1:0] coord_x,
	input  logic [vdh_pkg::COORD_W-1:0] coord_y,
	input  logic [vdh_pkg::COORD_W-1:0] coord_z,
	output logic                        done,
	output logic [BW-1:0]               bucket
);

	import vdh_pkg::*;

	localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			// two's complement low bits already give the non-negative remainder
			logic [BW-1:0] low_sum;

			assign low_sum = coord_x[BW-1:0] + coord_y[BW-1:0] + coord_z[BW-1:0];
			assign bucket  = (BUCKETS == 1) ? '0 : low_sum;
			assign done    = start;
		end else begin : g_recip
			localparam int SUM_W = 35;
			localparam int LO_W  = 17;
			localparam int HI_W  = SUM_W - LO_W;
			localparam int SHIFT = SUM_W + BW;
			localparam int M_W   = SUM_W + 2;
			localparam int PLO_W = LO_W + M_W;
			localparam int PHI_W = HI_W + M_W;
			localparam int ACC_W = SUM_W + M_W;
			// multiple of BUCKETS that lifts any three-coordinate sum above zero
			localparam logic [SUM_W-1:0] OFFS =
				SUM_W'(((64'd1 << 33) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS) * 64'(BUCKETS));
			// scaled reciprocal; exact quotient for every SUM_W-bit dividend
			localparam logic [M_W-1:0] RECIP =
				M_W'((64'd1 << SHIFT) / 64'(BUCKETS) + 64'd1);
			localparam logic [BW-1:0] BK = BW'(BUCKETS);

			logic [SUM_W-1:0] sum_ext;
			logic [SUM_W-1:0] u_q;
			logic [ACC_W-1:0] acc_q;
			logic [PLO_W-1:0] prod_lo;
			logic [PHI_W-1:0] prod_hi;
			logic [BW-1:0]    quot_lo;
			logic [BW-1:0]    qb_lo;
			logic [BW-1:0]    r_q;
			logic             ph1_q;
			logic             ph2_q;
			logic             ph3_q;
			logic             done_q;

			assign sum_ext = {{3{coord_x[COORD_W-1]}}, coord_x}
				+ {{3{coord_y[COORD_W-1]}}, coord_y}
				+ {{3{coord_z[COORD_W-1]}}, coord_z} + OFFS;

			// quotient by reciprocal multiply, low half then high half
			assign prod_lo = PLO_W'(u_q[LO_W-1:0]) * PLO_W'(RECIP);
			assign prod_hi = PHI_W'(u_q[SUM_W-1:LO_W]) * PHI_W'(RECIP);
			assign quot_lo = acc_q[SHIFT+BW-1:SHIFT];
			// remainder fits in BW bits, so only the low bits of quotient*BUCKETS matter
			assign qb_lo   = quot_lo * BK;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ph1_q  <= 1'b0;
					ph2_q  <= 1'b0;
					ph3_q  <= 1'b0;
					done_q <= 1'b0;
				end else begin
					ph1_q  <= start;
					ph2_q  <= ph1_q;
					ph3_q  <= ph2_q;
					done_q <= ph3_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					u_q <= sum_ext;
				end
				if (ph1_q) begin
					acc_q <= ACC_W'(prod_lo);
				end else if (ph2_q) begin
					acc_q <= acc_q + {prod_hi, {LO_W{1'b0}}};
				end
				if (ph3_q) begin
					r_q <= u_q[BW-1:0] - qb_lo;
				end
			end

			assign done   = done_q;
			assign bucket = r_q;
		end
	endgenerate

endmodule

FILE: rtl/core/vertex_dedup_hash_table_top.sv
// Vertex deduplication table: top level with bucket control, compare and result register.
//
// Each input transfer carries one mesh vertex (three signed 32-bit coordinates and its
// running index); each one yields exactly one result transfer that says whether the same
// vertex was seen before (found), or whether its bucket was full and it was dropped
// (overflow), plus its original and compacted indices. Entries live in one synchronous
// memory with one row per bucket holding all WAYS entries and their valid bits; an item
// reads its row, compares every way at once and, when it stores a new vertex, writes the
// updated row back. With a power-of-two BUCKETS the row read falls in the accept cycle,
// followed by compare and write-back, and the next item reads the row only after that
// write, so back-to-back items on the same bucket see each other. With any other BUCKETS
// the bucket number comes from a reciprocal multiply in three phases, and an item passes
// through accept, the three multiply-and-reduce phases, a bucket hand-over, row read and
// compare. After reset the block sweeps the memory once to clear the valid bits, one row
// per cycle, so s_axis_tready stays low until the sweep is done. A result waits in an
// output register; a stalled result output holds the compare stage only.
module vertex_dedup_hash_table_top #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input vertex stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], vertex_index[115:96], zero pad
	input  logic [vdh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// original_index[19:0], compacted_index[39:20]
	output logic [vdh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// found[0], overflow[1]
	output logic [vdh_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

	import vdh_pkg::*;

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * ENTRY_W;
	localparam bit POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

	state_t state_q, state_d;

	// input fields
	logic [COORD_W-1:0] in_x, in_y, in_z;
	logic [IDX_W-1:0]   in_idx;

	// latched item
	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [IDX_W-1:0]   vidx_q;
	logic [BW-1:0]      bucket_q;
	logic [IDX_W-1:0]   dup_q;
	logic [BW-1:0]      clr_q;

	// control
	logic accept;
	logic in_ready;
	logic mem_rd_en;
	logic clr_we;
	logic cmp_go;
	logic out_free;

	// hash unit
	logic          hash_done;
	logic [BW-1:0] bucket;

	// memory
	logic              mem_we;
	logic [BW-1:0]     mem_waddr;
	logic [ROW_W-1:0]  mem_wdata;
	logic [ROW_W-1:0]  mem_rdata;
	entry_t [WAYS-1:0] rd_row;
	entry_t [WAYS-1:0] new_row;
	entry_t            new_entry;

	// compare
	logic             hit_any;
	logic             free_any;
	logic [WW-1:0]    hit_sel;
	logic [WW-1:0]    free_sel;
	logic             store;
	logic [IDX_W-1:0] newc;

	// result register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [OUT_TUSER_W-1:0] m_user_q;

	assign in_x   = s_axis_tdata[COORD_W-1:0];
	assign in_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_z   = s_axis_tdata[3*COORD_W-1:2*COORD_W];
	assign in_idx = s_axis_tdata[3*COORD_W+IDX_W-1:3*COORD_W];

	assign accept   = s_axis_tvalid && in_ready;
	assign out_free = !m_valid_q || m_axis_tready;

	vdh_hash #(
		.BUCKETS (BUCKETS),
		.BW      (BW)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.coord_x (in_x),
		.coord_y (in_y),
		.coord_z (in_z),
		.done    (hash_done),
		.bucket  (bucket)
	);

	vdh_ram #(
		.DEPTH (BUCKETS),
		.AW    (BW),
		.DW    (ROW_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_rd_en),
		.rd_addr (bucket),
		.rd_data (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == BW'(BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = POW2 ? ST_CMP : ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_rd_en = 1'b0;
		clr_we    = 1'b0;
		cmp_go    = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE: begin
				in_ready  = 1'b1;
				// a power-of-two hash is ready in the accept cycle: read at once
				mem_rd_en = POW2 && s_axis_tvalid;
			end
			ST_HASH: ;
			ST_READ:  mem_rd_en = 1'b1;
			ST_CMP:   cmp_go = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			dup_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmp_go && hit_any) begin
				dup_q <= dup_q + 1'b1;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_x;
			y_q    <= in_y;
			z_q    <= in_z;
			vidx_q <= in_idx;
		end
		if (mem_rd_en) begin
			bucket_q <= bucket;
		end
	end

	// compare every way of the row; lowest matching way and lowest free way win
	assign rd_row = mem_rdata;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_sel  = '0;
		free_sel = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row[w].vld && rd_row[w].x == x_q && rd_row[w].y == y_q
					&& rd_row[w].z == z_q) begin
				hit_any = 1'b1;
				hit_sel = WW'(w);
			end
			if (!rd_row[w].vld) begin
				free_any = 1'b1;
				free_sel = WW'(w);
			end
		end
	end

	assign newc  = vidx_q - dup_q;
	assign store = !hit_any && free_any;

	always_comb begin
		new_entry.vld  = 1'b1;
		new_entry.x    = x_q;
		new_entry.y    = y_q;
		new_entry.z    = z_q;
		new_entry.orig = vidx_q;
		new_entry.comp = newc;
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			new_row[w] = (free_sel == WW'(w)) ? new_entry : rd_row[w];
		end
	end

	// the clearing sweep and the write-back share the write port
	assign mem_we    = clr_we || (cmp_go && store);
	assign mem_waddr = clr_we ? clr_q : bucket_q;
	assign mem_wdata = clr_we ? '0 : new_row;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmp_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_go) begin
			m_user_q[USER_FOUND]    <= hit_any;
			m_user_q[USER_OVERFLOW] <= !hit_any && !free_any;
			if (hit_any) begin
				m_data_q <= {rd_row[hit_sel].comp, rd_row[hit_sel].orig};
			end else begin
				m_data_q <= {newc, vidx_q};
			end
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
	// a result is never found and dropped at once
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[USER_FOUND] && m_axis_tuser[USER_OVERFLOW]))
		else $error("found and overflow both set");

	// the duplicate count moves only with a found result
	a_dup_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(dup_q != $past(dup_q)) |-> $past(cmp_go && hit_any))
		else $error("duplicate count changed without a hit");

	// row read and write-back never share an edge
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd_en && mem_we))
		else $error("row read overlaps row write");

	// write-back only lands when the result register can take the result
	a_wb_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clr_we) |=> m_axis_tvalid)
		else $error("row written without a result");
`endif

endmodule
